FILE: hdl/pps_pkg.sv
package pps_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic        valid;
		logic [7:0]  prio;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
	} cand_t;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} load_t;

	typedef struct packed {
		logic load;
		logic run;
	} ctl_t;

endpackage

FILE: hdl/preemptive_priority_scheduler_unit.sv
// Load beat: one load per cycle while no tick is in progress, no result beat.
// Tick beat: after the accept step (ST_IDLE), the candidates pass through the row
// of MAX_PROCS cells plus a settle step (ST_SCAN), then a compute step (ST_CALC)
// and a commit step (ST_DONE, held until the output is free); no beat is taken meanwhile.
// arst_n clears the clock, the counters, every cell's valid bit and the output.
module preemptive_priority_scheduler_unit import pps_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // arrival, burst, priority
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // slot, now, finished, turnaround, waiting, all_done
	output logic         m_tuser   // idle
);

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CALC, ST_DONE} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] proc_count_q;
	logic [CNT_W-1:0] done_count_q;
	logic [31:0]      clock_q;
	cand_t            best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0]      tat_q;
	logic             fin_q;
	logic             out_valid_q;
	logic [103:0]     out_data_q;
	logic             out_user_q;

	cand_t            chain [MAX_PROCS+1];
	logic [IDX_W-1:0] chain_idx [MAX_PROCS+1];

	ctl_t             ctl;
	logic [IDX_W-1:0] sel_idx;
	load_t            load_data;
	logic             in_fire;
	logic             out_free;
	logic             out_load;
	logic [31:0]      now_next;
	logic [31:0]      wt;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign now_next = clock_q + 32'd1;
	assign wt       = tat_q - {16'd0, best_q.burst};

	assign load_data.arrival = s_tdata[15:0];
	assign load_data.burst   = s_tdata[31:16];
	assign load_data.prio    = s_tdata[39:32];

	always_comb begin
		ctl.load = in_fire && (s_tuser == CMD_LOAD) && (proc_count_q != CNT_W'(MAX_PROCS));
		ctl.run  = (state_q == ST_DONE) && out_free && best_q.valid;
		sel_idx  = (state_q == ST_DONE) ? best_idx_q : proc_count_q[IDX_W-1:0];
	end

	assign chain[0]     = '0;
	assign chain_idx[0] = '0;

	for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
		pps_cell #(
			.IDX_W (IDX_W),
			.SLOT  (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.sel_idx      (sel_idx),
			.load_data    (load_data),
			.clock_now    (clock_q),
			.cand_in      (chain[i]),
			.cand_idx_in  (chain_idx[i]),
			.cand_out     (chain[i+1]),
			.cand_idx_out (chain_idx[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			proc_count_q <= '0;
			done_count_q <= '0;
			clock_q      <= '0;
			best_q       <= '0;
			best_idx_q   <= '0;
			tat_q        <= '0;
			fin_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_user_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						proc_count_q <= proc_count_q + CNT_W'(1);
					end
					if (in_fire && (s_tuser == CMD_TICK)) begin
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + CNT_W'(1);
					if (scan_q == CNT_W'(MAX_PROCS)) begin
						best_q     <= chain[MAX_PROCS];
						best_idx_q <= chain_idx[MAX_PROCS];
						state_q    <= ST_CALC;
					end
				end
				ST_CALC: begin
					tat_q   <= now_next - {16'd0, best_q.arrival};
					fin_q   <= best_q.valid && (best_q.remaining == 16'd1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						clock_q      <= now_next;
						done_count_q <= done_count_q + CNT_W'(fin_q);
						out_user_q   <= !best_q.valid;
						out_data_q[3:0]    <= best_q.valid ? 4'(best_idx_q) : 4'd0;
						out_data_q[35:4]   <= now_next;
						out_data_q[36]     <= fin_q;
						out_data_q[68:37]  <= fin_q ? tat_q : 32'd0;
						out_data_q[100:69] <= fin_q ? wt : 32'd0;
						out_data_q[101]    <= ((done_count_q + CNT_W'(fin_q)) == proc_count_q);
						out_data_q[103:102] <= 2'd0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

FILE: hdl/pps_cell.sv
module pps_cell import pps_pkg::*; #(
	parameter int IDX_W = 4,
	parameter int SLOT  = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic [IDX_W-1:0] sel_idx,
	input  load_t            load_data,
	input  logic [31:0]      clock_now,
	input  cand_t            cand_in,
	input  logic [IDX_W-1:0] cand_idx_in,
	output cand_t            cand_out,
	output logic [IDX_W-1:0] cand_idx_out
);

	logic        valid_q;
	logic [15:0] arrival_q;
	logic [15:0] burst_q;
	logic [15:0] remaining_q;
	logic [7:0]  prio_q;
	cand_t       cand_q;
	logic [IDX_W-1:0] cand_idx_q;

	logic  hit;
	logic  ready;
	logic  better;
	cand_t own;

	assign hit   = (sel_idx == IDX_W'(SLOT));
	assign ready = valid_q && ({16'd0, arrival_q} <= clock_now) && (remaining_q != 16'd0);

	always_comb begin
		own.valid     = 1'b1;
		own.prio      = prio_q;
		own.arrival   = arrival_q;
		own.burst     = burst_q;
		own.remaining = remaining_q;
		better = ready && (!cand_in.valid || (prio_q < cand_in.prio) ||
			((prio_q == cand_in.prio) && (arrival_q < cand_in.arrival)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load && hit) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && hit) begin
			arrival_q   <= load_data.arrival;
			burst_q     <= (load_data.burst == 16'd0) ? 16'd1 : load_data.burst;
			remaining_q <= (load_data.burst == 16'd0) ? 16'd1 : load_data.burst;
			prio_q      <= load_data.prio;
		end else if (ctl.run && hit) begin
			remaining_q <= remaining_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q     <= '0;
			cand_idx_q <= '0;
		end else if (better) begin
			cand_q     <= own;
			cand_idx_q <= IDX_W'(SLOT);
		end else begin
			cand_q     <= cand_in;
			cand_idx_q <= cand_idx_in;
		end
	end

	assign cand_out     = cand_q;
	assign cand_idx_out = cand_idx_q;

endmodule
